// File: rtl/usrd_pkg.sv
// ----------------------------------------------------------------------------
// usrd_pkg
// Types, request codes and the string length table for the setup request
// decoder.
// ----------------------------------------------------------------------------
package usrd_pkg;

  localparam int StringCount = 10;

  localparam logic [15:0] ReqDetach    = 16'h0021;
  localparam logic [15:0] ReqGetStatus = 16'h0080;
  localparam logic [15:0] ReqUpdStatus = 16'h03a1;
  localparam logic [15:0] ReqGetDesc   = 16'h0680;
  localparam logic [15:0] ReqSetAddr   = 16'h0500;
  localparam logic [15:0] ReqSetConfig = 16'h0900;
  localparam logic [15:0] ReqSetIface  = 16'h0b01;
  localparam logic [15:0] ReqSetFilter = 16'h4321;

  localparam logic [7:0] DescDevice    = 8'h01;
  localparam logic [7:0] DescConfig    = 8'h02;
  localparam logic [7:0] DescString    = 8'h03;
  localparam logic [7:0] DescQualifier = 8'h06;

  localparam logic [15:0] IfaceNet   = 16'h0001;
  localparam logic [15:0] IfaceMgmt  = 16'h0000;
  localparam logic [15:0] IfaceOther = 16'h0003;

  localparam logic [6:0] LenStatus    = 7'd2;
  localparam logic [6:0] LenUpdStatus = 7'd6;
  localparam logic [6:0] LenDevice    = 7'd18;
  localparam logic [6:0] LenConfig    = 7'd119;
  localparam logic [6:0] LenQualifier = 7'd10;

  localparam logic [9:0] BulkFull = 10'd64;
  localparam logic [9:0] BulkHigh = 10'd512;

  typedef enum logic [2:0] {
    KindEmpty     = 3'd0,
    KindDevice    = 3'd1,
    KindConfig    = 3'd2,
    KindQualifier = 3'd3,
    KindString    = 3'd4,
    KindStatus    = 3'd5,
    KindUpdate    = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    ChgNone  = 2'd0,
    ChgStart = 2'd1,
    ChgStop  = 2'd2
  } chg_e;

  typedef enum logic [1:0] {
    ActNone   = 2'd0,
    ActNotify = 2'd1,
    ActUpdate = 2'd2
  } act_e;

  typedef struct packed {
    logic [15:0] request_code;
    logic [15:0] request_value;
    logic [15:0] request_index;
    logic        high_speed;
  } req_t;

  typedef struct packed {
    logic        stall_res;
    kind_e       response_kind;
    logic [3:0]  string_number;
    logic [6:0]  resp_len;
    logic [9:0]  bulk_mps;
    logic        address_write;
    logic [6:0]  device_address;
    chg_e        mgmt_change;
    chg_e        network_change;
    act_e        after_action;
  } res_t;

  typedef struct packed {
    logic mgmt_running;
    logic net_running;
  } run_t;

  function automatic logic [6:0] str_len(input logic [3:0] idx);
    logic [6:0] len;
    case (idx)
      4'd0:    len = 7'd4;
      4'd1:    len = 7'd12;
      4'd2:    len = 7'd14;
      4'd3:    len = 7'd10;
      4'd4:    len = 7'd26;
      4'd5:    len = 7'd40;
      4'd6:    len = 7'd28;
      4'd7:    len = 7'd36;
      4'd8:    len = 7'd14;
      4'd9:    len = 7'd8;
      default: len = 7'd0;
    endcase
    return len;
  endfunction

endpackage

// File: rtl/usrd_decode.sv
// ----------------------------------------------------------------------------
// usrd_decode
// Decodes one setup request against the run flags and gives the result and
// the next run flags.
// ----------------------------------------------------------------------------
module usrd_decode (
  input  usrd_pkg::req_t req_i,
  input  usrd_pkg::run_t run_i,
  output usrd_pkg::res_t res_o,
  output usrd_pkg::run_t run_o
);
  import usrd_pkg::*;

  logic       ok;
  kind_e      kind;
  logic [3:0] snum;
  logic [6:0] len;
  logic       awr;
  logic [6:0] addr;
  chg_e       mchg;
  chg_e       nchg;
  act_e       act;
  logic [7:0] sidx;

  assign sidx = req_i.request_value[7:0];

  always_comb begin
    ok    = 1'b0;
    kind  = KindEmpty;
    snum  = 4'd0;
    len   = 7'd0;
    awr   = 1'b0;
    addr  = 7'd0;
    mchg  = ChgNone;
    nchg  = ChgNone;
    act   = ActNone;
    run_o = run_i;
    unique case (req_i.request_code)
      ReqDetach: begin
        ok  = 1'b1;
        act = ActUpdate;
      end
      ReqGetStatus: begin
        ok   = 1'b1;
        kind = KindStatus;
        len  = LenStatus;
      end
      ReqUpdStatus: begin
        ok   = 1'b1;
        kind = KindUpdate;
        len  = LenUpdStatus;
      end
      ReqGetDesc: begin
        unique case (req_i.request_value[15:8])
          DescDevice: begin
            ok   = 1'b1;
            kind = KindDevice;
            len  = LenDevice;
          end
          DescConfig: begin
            ok   = 1'b1;
            kind = KindConfig;
            len  = LenConfig;
          end
          DescQualifier: begin
            ok   = 1'b1;
            kind = KindQualifier;
            len  = LenQualifier;
          end
          DescString: begin
            if (sidx < 8'(StringCount)) begin
              ok   = 1'b1;
              kind = KindString;
              snum = sidx[3:0];
              len  = str_len(sidx[3:0]);
            end
          end
          default: begin
          end
        endcase
      end
      ReqSetAddr: begin
        ok   = 1'b1;
        awr  = 1'b1;
        addr = req_i.request_value[6:0];
        if (req_i.request_value[6:0] == 7'd0) begin
          if (run_i.net_running) begin
            nchg              = ChgStop;
            run_o.net_running = 1'b0;
          end
          if (run_i.mgmt_running) begin
            mchg               = ChgStop;
            run_o.mgmt_running = 1'b0;
          end
        end
      end
      ReqSetConfig: begin
        ok  = 1'b1;
        act = ActNotify;
        if (run_i.net_running) begin
          nchg              = ChgStop;
          run_o.net_running = 1'b0;
        end
        if (!run_i.mgmt_running) begin
          mchg               = ChgStart;
          run_o.mgmt_running = 1'b1;
        end
      end
      ReqSetIface: begin
        if (req_i.request_index == IfaceNet) begin
          ok = 1'b1;
          if (req_i.request_value != 16'd0) begin
            act = ActNotify;
            if (!run_i.net_running) begin
              nchg              = ChgStart;
              run_o.net_running = 1'b1;
            end
          end else if (run_i.net_running) begin
            nchg              = ChgStop;
            run_o.net_running = 1'b0;
          end
        end else if (req_i.request_index == IfaceMgmt ||
                     req_i.request_index == IfaceOther) begin
          ok = 1'b1;
        end
      end
      ReqSetFilter: begin
        ok = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_o.stall_res      = !ok;
    res_o.response_kind  = ok ? kind : KindEmpty;
    res_o.string_number  = ok ? snum : 4'd0;
    res_o.resp_len       = ok ? len : 7'd0;
    res_o.bulk_mps       = req_i.high_speed ? BulkHigh : BulkFull;
    res_o.address_write  = ok & awr;
    res_o.device_address = ok ? addr : 7'd0;
    res_o.mgmt_change    = ok ? mchg : ChgNone;
    res_o.network_change = ok ? nchg : ChgNone;
    res_o.after_action   = ok ? act : ActNone;
  end

endmodule

// File: rtl/usb_setup_request_decoder.sv
// ----------------------------------------------------------------------------
// usb_setup_request_decoder
// Setup request decoder with management and network run flags.
// ----------------------------------------------------------------------------
// Takes one setup request per clock cycle while req_stall_o is low. A request
// accepted is held in the input register, decoded in the following cycle and
// moved into the result register once that register is free or being taken;
// its result is offered from there. The run flags are updated when a request
// moves into the result register, so a request decoded in the very next cycle
// sees them. Throughput is one request per cycle and is set only by the result
// register handshake: while a result waits, one more request is taken into the
// input register, and further requests stall.
module usb_setup_request_decoder (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_stall_o,
  input  usrd_pkg::req_t req_i,
  output logic           res_valid_o,
  input  logic           res_stall_i,
  output usrd_pkg::res_t res_o
);
  import usrd_pkg::*;

  logic in_vld_q;
  logic in_vld_d;
  req_t in_req_q;
  logic res_vld_q;
  logic res_vld_d;
  res_t res_q;
  res_t res_d;
  run_t run_q;
  run_t run_d;
  run_t run_nxt;
  logic in_load;
  logic res_load;

  usrd_decode u_decode (
    .req_i (in_req_q),
    .run_i (run_q),
    .res_o (res_d),
    .run_o (run_nxt)
  );

  assign res_load    = in_vld_q & (~res_vld_q | ~res_stall_i);
  assign req_stall_o = in_vld_q & res_vld_q & res_stall_i;
  assign in_load     = req_valid_i & ~req_stall_o;
  assign in_vld_d    = in_load | (in_vld_q & ~res_load);
  assign res_vld_d   = res_load | (res_vld_q & res_stall_i);
  assign run_d       = res_load ? run_nxt : run_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
      run_q     <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      res_vld_q <= res_vld_d;
      run_q     <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_req_q <= req_i;
    end
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule

// File: rtl/usrd_checker.sv
// ----------------------------------------------------------------------------
// usrd_checker
// Port-level checks for the setup request decoder, bound to the top level.
// ----------------------------------------------------------------------------
module usrd_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           req_stall_o,
  input logic           res_valid_o,
  input logic           res_stall_i,
  input usrd_pkg::res_t res_o
);
  import usrd_pkg::*;

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_stall_i |=> res_valid_o)
    else $error("result dropped while stalled");

  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_stall_i |=> $stable(res_o))
    else $error("stalled result changed");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_stall_o |-> res_valid_o && res_stall_i)
    else $error("request stalled with result side free");

  a_stall_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.stall_res |->
      res_o.response_kind == KindEmpty && res_o.resp_len == 7'd0 &&
      !res_o.address_write && res_o.mgmt_change == ChgNone &&
      res_o.network_change == ChgNone && res_o.after_action == ActNone)
    else $error("stalled request carries side effects");

  a_bulk_mps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> res_o.bulk_mps == BulkHigh || res_o.bulk_mps == BulkFull)
    else $error("bad bulk packet size");

endmodule

bind usb_setup_request_decoder usrd_checker u_usrd_checker (.*);
